[src/pbi_pkg.sv]
// shared types, constants, fixed-point helpers and microcode for the breakpoint solver
package pbi_pkg;

  // widths
  localparam int FW          = 32;   // one Q16.16 input or output field
  localparam int IN_W        = 160;  // five packed input fields
  localparam int VW          = 64;   // working value width
  localparam int MW          = 62;   // magnitude width of a working value
  localparam int RA_W        = 5;    // working register address
  localparam int RF_DEPTH    = 32;   // working register file entries
  localparam int PC_W        = 7;    // microcode address
  localparam int EPS_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [VW-1:0] FXMAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  // item classes
  localparam logic [1:0] CLS_EQX = 2'd0;
  localparam logic [1:0] CLS_EQY = 2'd1;
  localparam logic [1:0] CLS_GEN = 2'd2;

  // micro operations
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_NEG  = 3'd2;
  localparam logic [2:0] OP_HALF = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_SQRT = 3'd6;
  localparam logic [2:0] OP_END  = 3'd7;

  // working registers
  localparam logic [RA_W-1:0] R_AX  = 5'd0;
  localparam logic [RA_W-1:0] R_AY  = 5'd1;
  localparam logic [RA_W-1:0] R_BX  = 5'd2;
  localparam logic [RA_W-1:0] R_BY  = 5'd3;
  localparam logic [RA_W-1:0] R_DL  = 5'd4;
  localparam logic [RA_W-1:0] R_T0  = 5'd5;
  localparam logic [RA_W-1:0] R_T1  = 5'd6;
  localparam logic [RA_W-1:0] R_T2  = 5'd7;
  localparam logic [RA_W-1:0] R_T3  = 5'd8;
  localparam logic [RA_W-1:0] R_T4  = 5'd9;
  localparam logic [RA_W-1:0] R_T5  = 5'd10;
  localparam logic [RA_W-1:0] R_T6  = 5'd11;
  localparam logic [RA_W-1:0] R_T7  = 5'd12;
  localparam logic [RA_W-1:0] R_T8  = 5'd13;
  localparam logic [RA_W-1:0] R_T9  = 5'd14;
  localparam logic [RA_W-1:0] R_T10 = 5'd15;
  localparam logic [RA_W-1:0] R_T11 = 5'd16;
  localparam logic [RA_W-1:0] R_PX0 = 5'd24;
  localparam logic [RA_W-1:0] R_PY0 = 5'd25;
  localparam logic [RA_W-1:0] R_PX1 = 5'd26;
  localparam logic [RA_W-1:0] R_PY1 = 5'd27;

  // program entry points
  localparam logic [PC_W-1:0] PC_EQX = 7'd0;
  localparam logic [PC_W-1:0] PC_EQY = 7'd12;
  localparam logic [PC_W-1:0] PC_GEN = 7'd24;

  typedef struct packed {
    logic [2:0]      op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] sa;
    logic [RA_W-1:0] sb;
  } uop_t;

  typedef struct packed {
    logic signed [VW-1:0] val;
    logic                 flt;
  } fx_t;

  typedef struct packed {
    logic signed [FW-1:0] val;
    logic                 flt;
  } sat_t;

  // queue entry from front to back
  typedef struct packed {
    logic [1:0]      cls;
    logic [IN_W-1:0] data;
  } qent_t;

  // finished item from core to output stage
  typedef struct packed {
    logic signed [VW-1:0] px0;
    logic signed [VW-1:0] py0;
    logic signed [VW-1:0] px1;
    logic signed [VW-1:0] py1;
    logic                 two;
    logic                 flt;
  } res_t;

  // clamp a grown sum into the working range
  function automatic fx_t fx_fit(input logic signed [VW:0] s);
    logic signed [VW:0] hi;
    fx_t r;
    hi = {FXMAX[VW-1], FXMAX};
    if (s > hi) begin
      r = '{FXMAX, 1'b1};
    end else if (s < -hi) begin
      r = '{-FXMAX, 1'b1};
    end else begin
      r = '{s[VW-1:0], 1'b0};
    end
    return r;
  endfunction

  // halve with truncation toward zero
  function automatic logic signed [VW-1:0] fx_half(input logic signed [VW-1:0] a);
    logic signed [VW-1:0] t;
    t = a + $signed({{(VW-1){1'b0}}, a[VW-1]});
    return t >>> 1;
  endfunction

  // magnitude of a working value
  function automatic logic [MW-1:0] fx_mag(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = v[VW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  // sign and magnitude back to a working value, saturating on overflow
  function automatic fx_t fx_signmag(input logic [MW-1:0] m, input logic neg,
                                     input logic ovf);
    logic [MW-1:0]        mm;
    logic signed [VW-1:0] v;
    fx_t r;
    mm = ovf ? FXMAX[MW-1:0] : m;
    v = $signed({{(VW-MW){1'b0}}, mm});
    r = '{neg ? -v : v, ovf};
    return r;
  endfunction

  // saturate a working value to an output field
  function automatic sat_t sat32(input logic signed [VW-1:0] v);
    sat_t r;
    if (&v[VW-1:FW-1] || ~|v[VW-1:FW-1]) begin
      r = '{v[FW-1:0], 1'b0};
    end else if (v[VW-1]) begin
      r = '{{1'b1, {(FW-1){1'b0}}}, 1'b1};
    end else begin
      r = '{{1'b0, {(FW-1){1'b1}}}, 1'b1};
    end
    return r;
  endfunction

  function automatic logic [PC_W-1:0] start_pc(input logic [1:0] cls);
    logic [PC_W-1:0] p;
    case (cls)
      CLS_EQX: p = PC_EQX;
      CLS_EQY: p = PC_EQY;
      default: p = PC_GEN;
    endcase
    return p;
  endfunction

  // microcode store
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // foci share x
      7'd0:  u = '{OP_ADD,  R_T0,  R_AY,  R_BY};
      7'd1:  u = '{OP_MUL,  R_T1,  R_DL,  R_DL};
      7'd2:  u = '{OP_MUL,  R_T2,  R_DL,  R_T0};
      7'd3:  u = '{OP_SUB,  R_T1,  R_T1,  R_T2};
      7'd4:  u = '{OP_MUL,  R_T2,  R_AY,  R_BY};
      7'd5:  u = '{OP_ADD,  R_T1,  R_T1,  R_T2};
      7'd6:  u = '{OP_SQRT, R_T2,  R_T1,  R_T1};
      7'd7:  u = '{OP_SUB,  R_PX0, R_AX,  R_T2};
      7'd8:  u = '{OP_HALF, R_PY0, R_T0,  R_T0};
      7'd9:  u = '{OP_ADD,  R_PX1, R_AX,  R_T2};
      7'd10: u = '{OP_HALF, R_PY1, R_T0,  R_T0};
      7'd11: u = '{OP_END,  R_T0,  R_T0,  R_T0};
      // foci share y
      7'd12: u = '{OP_ADD,  R_T0,  R_AX,  R_BX};
      7'd13: u = '{OP_HALF, R_PX0, R_T0,  R_T0};
      7'd14: u = '{OP_SUB,  R_T1,  R_PX0, R_AX};
      7'd15: u = '{OP_MUL,  R_T1,  R_T1,  R_T1};
      7'd16: u = '{OP_MUL,  R_T2,  R_AY,  R_AY};
      7'd17: u = '{OP_ADD,  R_T1,  R_T1,  R_T2};
      7'd18: u = '{OP_MUL,  R_T2,  R_DL,  R_DL};
      7'd19: u = '{OP_SUB,  R_T1,  R_T1,  R_T2};
      7'd20: u = '{OP_HALF, R_T1,  R_T1,  R_T1};
      7'd21: u = '{OP_SUB,  R_T2,  R_AY,  R_DL};
      7'd22: u = '{OP_DIV,  R_PY0, R_T1,  R_T2};
      7'd23: u = '{OP_END,  R_T0,  R_T0,  R_T0};
      // general quadratic
      7'd24: u = '{OP_SUB,  R_T0,  R_AX,  R_BX};
      7'd25: u = '{OP_SUB,  R_T1,  R_AY,  R_BY};
      7'd26: u = '{OP_MUL,  R_T2,  R_T0,  R_T0};
      7'd27: u = '{OP_MUL,  R_T3,  R_T1,  R_T1};
      7'd28: u = '{OP_ADD,  R_T4,  R_T2,  R_T3};
      7'd29: u = '{OP_ADD,  R_T5,  R_AY,  R_BY};
      7'd30: u = '{OP_SUB,  R_T6,  R_DL,  R_AY};
      7'd31: u = '{OP_MUL,  R_T6,  R_T2,  R_T6};
      7'd32: u = '{OP_SUB,  R_T7,  R_DL,  R_BY};
      7'd33: u = '{OP_MUL,  R_T6,  R_T6,  R_T7};
      7'd34: u = '{OP_MUL,  R_T6,  R_T6,  R_T4};
      7'd35: u = '{OP_SQRT, R_T6,  R_T6,  R_T6};
      7'd36: u = '{OP_ADD,  R_T6,  R_T6,  R_T6};
      7'd37: u = '{OP_MUL,  R_T7,  R_DL,  R_T2};
      7'd38: u = '{OP_ADD,  R_T7,  R_T7,  R_T7};
      7'd39: u = '{OP_NEG,  R_T7,  R_T7,  R_T7};
      7'd40: u = '{OP_MUL,  R_T8,  R_T5,  R_T4};
      7'd41: u = '{OP_ADD,  R_T7,  R_T7,  R_T8};
      7'd42: u = '{OP_ADD,  R_T8,  R_T3,  R_T3};
      7'd43: u = '{OP_MUL,  R_T9,  R_AX,  R_AX};
      7'd44: u = '{OP_MUL,  R_T10, R_BX,  R_BX};
      7'd45: u = '{OP_SUB,  R_T9,  R_T9,  R_T10};
      7'd46: u = '{OP_SUB,  R_T10, R_BY,  R_AY};
      7'd47: u = '{OP_SUB,  R_T11, R_T7,  R_T6};
      7'd48: u = '{OP_DIV,  R_PY0, R_T11, R_T8};
      7'd49: u = '{OP_ADD,  R_T11, R_T7,  R_T6};
      7'd50: u = '{OP_DIV,  R_PY1, R_T11, R_T8};
      7'd51: u = '{OP_ADD,  R_T11, R_PY0, R_PY0};
      7'd52: u = '{OP_SUB,  R_T11, R_T11, R_BY};
      7'd53: u = '{OP_SUB,  R_T11, R_T11, R_AY};
      7'd54: u = '{OP_MUL,  R_T11, R_T11, R_T10};
      7'd55: u = '{OP_ADD,  R_T11, R_T9,  R_T11};
      7'd56: u = '{OP_HALF, R_T11, R_T11, R_T11};
      7'd57: u = '{OP_DIV,  R_PX0, R_T11, R_T0};
      7'd58: u = '{OP_ADD,  R_T11, R_PY1, R_PY1};
      7'd59: u = '{OP_SUB,  R_T11, R_T11, R_BY};
      7'd60: u = '{OP_SUB,  R_T11, R_T11, R_AY};
      7'd61: u = '{OP_MUL,  R_T11, R_T11, R_T10};
      7'd62: u = '{OP_ADD,  R_T11, R_T9,  R_T11};
      7'd63: u = '{OP_HALF, R_T11, R_T11, R_T11};
      7'd64: u = '{OP_DIV,  R_PX1, R_T11, R_T0};
      default: u = '{OP_END, R_T0, R_T0, R_T0};
    endcase
    return u;
  endfunction

endpackage

[src/parabola_breakpoint_intersect.sv]
// top level: configuration register, front queue, microcoded core and output stage
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata: two foci and the directrix
//  m_*       out  m_tvalid / m_tready  m_tdata: one point, m_tlast, m_tuser: error
//  cfg_*     in   cfg_wr_en            cfg_wr_data: coincide_epsilon
//
// in the core, 78-step divides, a 40-step root and 5-step multiplies set how long an item takes,
// plus one working register read per micro-op; a zero divisor or negative root ends early
// the front queue keeps taking beats until full, while the core works and the output stage drains
// rst is synchronous; it empties the queue, idles core and output, sets coincide_epsilon to 1
// a stalled m_tready holds the current point; the core then waits with its result
module parabola_breakpoint_intersect import pbi_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // focus1_x, focus1_y, focus2_x, focus2_y, directrix_y
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // point_x, point_y
  output logic [2*FW-1:0]  m_tdata,
  output logic             m_tlast,
  // math_error
  output logic             m_tuser,
  input  logic             cfg_wr_en,
  input  logic [EPS_W-1:0] cfg_wr_data
);

  logic [EPS_W-1:0] eps;
  logic             q_valid;
  qent_t            q_head;
  logic             q_pop;
  res_t             res;
  logic             res_valid;
  logic             res_ready;

  logic             ob_full;
  logic             ob_idx;
  logic             ob_two;
  logic             ob_flt;
  logic [FW-1:0]    ox0, oy0, ox1, oy1;

  logic                 swap;
  logic signed [VW-1:0] sx0, sy0, sx1, sy1;
  sat_t                 tx0, ty0, tx1, ty1;
  logic                 tot_flt;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_W'(1);
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  pbi_front #(.DEPTH(QDEPTH)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .eps(eps), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  pbi_core u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .res(res), .res_valid(res_valid), .res_ready(res_ready)
  );

  // order by x and saturate to the output fields
  always_comb begin
    swap = res.two && (res.px0 > res.px1);
    sx0  = swap ? res.px1 : res.px0;
    sy0  = swap ? res.py1 : res.py0;
    sx1  = swap ? res.px0 : res.px1;
    sy1  = swap ? res.py0 : res.py1;
    tx0  = sat32(sx0);
    ty0  = sat32(sy0);
    tx1  = sat32(sx1);
    ty1  = sat32(sy1);
    tot_flt = res.flt || tx0.flt || ty0.flt || (res.two && (tx1.flt || ty1.flt));
  end

  assign res_ready = !ob_full;

  // output point registers
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ox0    <= tx0.val;
      oy0    <= ty0.val;
      ox1    <= tx1.val;
      oy1    <= ty1.val;
      ob_two <= res.two;
      ob_flt <= tot_flt;
    end
  end

  // output beat control
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_full <= 1'b0;
      ob_idx  <= 1'b0;
    end else if (res_valid && res_ready) begin
      ob_full <= 1'b1;
      ob_idx  <= 1'b0;
    end else if (ob_full && m_tready) begin
      if (!ob_idx && ob_two) begin
        ob_idx <= 1'b1;
      end else begin
        ob_full <= 1'b0;
      end
    end
  end

  assign m_tvalid = ob_full;
  assign m_tdata  = ob_idx ? {oy1, ox1} : {oy0, ox0};
  assign m_tlast  = ob_idx || !ob_two;
  assign m_tuser  = ob_flt;

endmodule

[src/pbi_ram.sv]
// generic single-write, single-read ram with registered read data
module pbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pbi_front.sv]
// input side: accepts beats, sorts them into the three cases, queues them for the core
module pbi_front import pbi_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [EPS_W-1:0] eps,
  output logic             q_valid,
  output qent_t            q_head,
  input  logic             q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic signed [FW:0] diff_x;
  logic signed [FW:0] diff_y;
  logic [FW:0]        mag_x;
  logic [FW:0]        mag_y;
  logic [1:0]         cls;
  logic               push;

  // case selection on the incoming beat
  always_comb begin
    diff_x = $signed({s_tdata[FW-1], s_tdata[FW-1:0]})
           - $signed({s_tdata[3*FW-1], s_tdata[3*FW-1:2*FW]});
    diff_y = $signed({s_tdata[2*FW-1], s_tdata[2*FW-1:FW]})
           - $signed({s_tdata[4*FW-1], s_tdata[4*FW-1:3*FW]});
    mag_x = diff_x[FW] ? 33'(-diff_x) : 33'(diff_x);
    mag_y = diff_y[FW] ? 33'(-diff_y) : 33'(diff_y);
    if (mag_x < {{(FW+1-EPS_W){1'b0}}, eps}) begin
      cls = CLS_EQX;
    end else if (mag_y < {{(FW+1-EPS_W){1'b0}}, eps}) begin
      cls = CLS_EQY;
    end else begin
      cls = CLS_GEN;
    end
  end

  assign s_tready = (count != CW'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_head   = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{cls, s_tdata};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/pbi_arith.sv]
// multi-cycle unit: 4-part multiplier, restoring divider, digit-by-digit square root
module pbi_arith import pbi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           op,
  input  logic signed [VW-1:0] a,
  input  logic signed [VW-1:0] b,
  output logic                 done,
  output fx_t                  res
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_DIV  = 3'd2;
  localparam logic [2:0] A_SQRT = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  localparam int HW  = MW / 2;        // half of a magnitude
  localparam int PPW = 2 * HW;        // one partial product
  localparam int AW  = 2 * MW;        // full product
  localparam int QW  = MW + 16;       // quotient bits
  localparam int NW  = 80;            // numerator / radicand shifter
  localparam int RW  = 40;            // root bits
  localparam int SRW = RW + 2;        // root remainder

  logic [2:0]     st;
  logic [2:0]     kind;
  logic           neg;
  logic           spec;
  logic [6:0]     cnt;
  logic [MW-1:0]  ma;
  logic [MW-1:0]  mb;
  logic [PPW-1:0] pp;
  logic [AW-1:0]  acc;
  logic [NW-1:0]  nsh;
  logic [MW-1:0]  rem;
  logic [QW-1:0]  quo;
  logic [RW-1:0]  root;
  logic [SRW-1:0] srem;

  logic [HW-1:0]  xa;
  logic [HW-1:0]  xb;
  logic [2:0]     prev;
  logic [AW-1:0]  pp_sh;
  logic [MW:0]    dtry;
  logic [MW:0]    ddif;
  logic [SRW+1:0] strl;
  logic [SRW+1:0] stry;
  logic [SRW+1:0] sdif;

  // partial product operands and alignment
  always_comb begin
    xa   = cnt[1] ? ma[MW-1:HW] : ma[HW-1:0];
    xb   = cnt[0] ? mb[MW-1:HW] : mb[HW-1:0];
    prev = cnt[2:0] - 3'd1;
    case (prev)
      3'd0:    pp_sh = {{(AW-PPW){1'b0}}, pp};
      3'd3:    pp_sh = {{(AW-PPW){1'b0}}, pp} << (2 * HW);
      default: pp_sh = {{(AW-PPW){1'b0}}, pp} << HW;
    endcase
  end

  // divider and root trial steps
  always_comb begin
    dtry = {rem, nsh[NW-1]};
    ddif = dtry - {1'b0, mb};
    strl = {srem, nsh[NW-1:NW-2]};
    stry = {{(SRW+2-RW-2){1'b0}}, root, 2'b01};
    sdif = strl - stry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
    end else begin
      case (st)
        A_IDLE: begin
          if (start) begin
            if (op == OP_MUL) begin
              st <= A_MUL;
            end else if (op == OP_DIV) begin
              st <= (b == '0) ? A_FIN : A_DIV;
            end else begin
              st <= a[VW-1] ? A_FIN : A_SQRT;
            end
          end
        end
        A_MUL:  if (cnt == 7'd4) st <= A_FIN;
        A_DIV:  if (cnt == 7'(QW - 1)) st <= A_FIN;
        A_SQRT: if (cnt == 7'(RW - 1)) st <= A_FIN;
        A_FIN:  st <= A_IDLE;
        default: st <= A_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      A_IDLE: begin
        if (start) begin
          kind <= op;
          neg  <= (op != OP_SQRT) && (a[VW-1] ^ b[VW-1]);
          spec <= (op == OP_DIV) ? (b == '0) : ((op == OP_SQRT) && a[VW-1]);
          ma   <= fx_mag(a);
          mb   <= fx_mag(b);
          cnt  <= '0;
          acc  <= '0;
          rem  <= '0;
          quo  <= '0;
          root <= '0;
          srem <= '0;
          if (op == OP_DIV) begin
            nsh <= {fx_mag(a), 16'd0, 2'd0};
          end else begin
            nsh <= {2'd0, fx_mag(a), 16'd0};
          end
        end
      end
      A_MUL: begin
        if (cnt < 7'd4) begin
          pp <= xa * xb;
        end
        if (cnt != '0) begin
          acc <= acc + pp_sh;
        end
        cnt <= cnt + 1'b1;
      end
      A_DIV: begin
        if (!ddif[MW]) begin
          rem <= ddif[MW-1:0];
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= dtry[MW-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
        nsh <= nsh << 1;
        cnt <= cnt + 1'b1;
      end
      A_SQRT: begin
        if (strl >= stry) begin
          srem <= sdif[SRW-1:0];
          root <= {root[RW-2:0], 1'b1};
        end else begin
          srem <= strl[SRW-1:0];
          root <= {root[RW-2:0], 1'b0};
        end
        nsh <= nsh << 2;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign done = (st == A_FIN);

  // final sign, saturation and special cases
  always_comb begin
    case (kind)
      OP_MUL:  res = fx_signmag(acc[MW+15:16], neg, |acc[AW-1:MW+16]);
      OP_DIV:  res = spec ? '{'0, 1'b1} : fx_signmag(quo[MW-1:0], neg, |quo[QW-1:MW]);
      OP_SQRT: res = spec ? '{'0, 1'b1} : '{$signed({{(VW-RW){1'b0}}, root}), 1'b0};
      default: res = '{'0, 1'b0};
    endcase
  end

endmodule

[src/pbi_core.sv]
// back end: microcoded sequencer over a working register file and the arithmetic units
module pbi_core import pbi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  qent_t q_head,
  output logic  q_pop,
  output res_t  res,
  output logic  res_valid,
  input  logic  res_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state;
  logic [PC_W-1:0] pc;
  logic [2:0]      ld_cnt;
  logic [1:0]      cls;
  logic            flt;
  logic signed [VW-1:0] px0, py0, px1, py1;

  uop_t                 ins;
  logic                 is_long;
  logic                 we;
  logic [RA_W-1:0]      waddr;
  logic signed [VW-1:0] wdata;
  logic [VW-1:0]        rd_a;
  logic [VW-1:0]        rd_b;
  logic signed [VW:0]   op_a;
  logic signed [VW:0]   op_b;
  fx_t                  alu;
  logic                 ar_start;
  logic                 ar_done;
  fx_t                  ar_res;
  logic                 step_flt;

  assign ins     = ucode(pc);
  assign is_long = (ins.op == OP_MUL) || (ins.op == OP_DIV) || (ins.op == OP_SQRT);

  // two copies of the working registers give two read ports
  pbi_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ins.sa), .rdata(rd_a)
  );
  pbi_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ins.sb), .rdata(rd_b)
  );

  // short operations, computed combinationally from the register reads
  always_comb begin
    op_a = $signed({rd_a[VW-1], rd_a});
    op_b = $signed({rd_b[VW-1], rd_b});
    case (ins.op)
      OP_ADD:  alu = fx_fit(op_a + op_b);
      OP_SUB:  alu = fx_fit(op_a - op_b);
      OP_NEG:  alu = fx_fit(-op_a);
      OP_HALF: alu = '{fx_half($signed(rd_a)), 1'b0};
      default: alu = '{'0, 1'b0};
    endcase
  end

  assign ar_start = (state == S_EXEC) && is_long;

  pbi_arith u_arith (
    .clk(clk), .rst(rst), .start(ar_start), .op(ins.op),
    .a($signed(rd_a)), .b($signed(rd_b)), .done(ar_done), .res(ar_res)
  );

  // register file write selection
  always_comb begin
    we       = 1'b0;
    waddr    = ins.dst;
    wdata    = alu.val;
    step_flt = 1'b0;
    case (state)
      S_LOAD: begin
        we    = 1'b1;
        waddr = {{(RA_W-3){1'b0}}, ld_cnt};
        wdata = $signed({{(VW-FW){q_head.data[{ld_cnt, 5'd0} + 8'd31]}},
                         q_head.data[{ld_cnt, 5'd0} +: FW]});
      end
      S_EXEC: begin
        we       = !is_long && (ins.op != OP_END);
        step_flt = alu.flt;
      end
      S_WAIT: begin
        we       = ar_done;
        wdata    = ar_res.val;
        step_flt = ar_done && ar_res.flt;
      end
      default: begin
      end
    endcase
  end

  assign q_pop = (state == S_LOAD) && (ld_cnt == 3'd4);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      ld_cnt <= '0;
      cls    <= CLS_GEN;
      flt    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state  <= S_LOAD;
            ld_cnt <= '0;
          end
        end
        S_LOAD: begin
          ld_cnt <= ld_cnt + 1'b1;
          if (ld_cnt == 3'd4) begin
            state <= S_ISSUE;
            pc    <= start_pc(q_head.cls);
            cls   <= q_head.cls;
            flt   <= 1'b0;
          end
        end
        S_ISSUE: begin
          state <= (ins.op == OP_END) ? S_DONE : S_EXEC;
        end
        S_EXEC: begin
          if (is_long) begin
            state <= S_WAIT;
          end else begin
            state <= S_ISSUE;
            pc    <= pc + 1'b1;
            flt   <= flt | step_flt;
          end
        end
        S_WAIT: begin
          if (ar_done) begin
            state <= S_ISSUE;
            pc    <= pc + 1'b1;
            flt   <= flt | step_flt;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // keep a copy of the result registers as they are written
  always_ff @(posedge clk) begin
    if (we && (state != S_LOAD)) begin
      case (waddr)
        R_PX0:   px0 <= wdata;
        R_PY0:   py0 <= wdata;
        R_PX1:   px1 <= wdata;
        R_PY1:   py1 <= wdata;
        default: begin
        end
      endcase
    end
  end

  assign res_valid = (state == S_DONE);
  assign res       = '{px0, py0, px1, py1, (cls != CLS_EQY), flt};

endmodule

[test/tb_top.sv]
// testbench for the parabola breakpoint solver: directed and random foci against a fixed-point predictor
`timescale 1ns / 100ps

module tb_top;
  import pbi_pkg::*;

  localparam longint FX_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    int f1x;
    int f1y;
    int f2x;
    int f2y;
    int dl;
  } foci_t;

  typedef struct {
    logic [FW-1:0] px;
    logic [FW-1:0] py;
    logic          last;
    logic          err;
  } point_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [2*FW-1:0]  m_tdata;
  logic             m_tlast;
  logic             m_tuser;
  logic             cfg_wr_en;
  logic [EPS_W-1:0] cfg_wr_data;

  point_t       pending_points[$];
  logic [15:0]  eps_model;
  bit           calc_err;
  int           src_idle;
  int           snk_idle;
  int           mismatches;
  int           items_sent;
  int           points_seen;
  int           error_points;

  parabola_breakpoint_intersect dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("timeout with %0d points outstanding", pending_points.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // fixed-point arithmetic of the solver
  function automatic longint fx_clamp(longint s);
    if (s > FX_LIMIT) begin
      calc_err = 1'b1;
      return FX_LIMIT;
    end
    if (s < -FX_LIMIT) begin
      calc_err = 1'b1;
      return -FX_LIMIT;
    end
    return s;
  endfunction

  function automatic logic [63:0] fx_abs(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fx_from_mag(logic [63:0] m, bit neg, bit ovf);
    logic [63:0] mm;
    mm = m;
    if (ovf || mm > 64'(FX_LIMIT)) begin
      calc_err = 1'b1;
      mm = 64'(FX_LIMIT);
    end
    return neg ? -longint'(mm) : longint'(mm);
  endfunction

  function automatic longint fx_mult(longint a, longint b);
    logic [127:0] p;
    p = {64'b0, fx_abs(a)} * {64'b0, fx_abs(b)};
    return fx_from_mag(p[79:16], (a < 0) != (b < 0), |p[127:80]);
  endfunction

  function automatic longint fx_quot(longint a, longint b);
    logic [127:0] q;
    if (b == 0) begin
      calc_err = 1'b1;
      return 0;
    end
    q = ({64'b0, fx_abs(a)} << 16) / {64'b0, fx_abs(b)};
    return fx_from_mag(q[63:0], (a < 0) != (b < 0), |q[127:64]);
  endfunction

  function automatic longint fx_root(longint a);
    logic [127:0] n;
    logic [127:0] r;
    logic [127:0] c;
    if (a < 0) begin
      calc_err = 1'b1;
      return 0;
    end
    n = {64'b0, a} << 16;
    r = '0;
    for (int i = 39; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= n) r = c;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic logic [FW-1:0] fx_to_out(longint v);
    if (v > 64'sd2147483647) begin
      calc_err = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      calc_err = 1'b1;
      return 32'h8000_0000;
    end
    return v[FW-1:0];
  endfunction

  // intersection points expected for one item
  function automatic void predict_breakpoints(foci_t it);
    longint ax, ay, bx, by, dl;
    longint px[2];
    longint py[2];
    longint sy, rad, rt, mx, ex, num, dx, dy, dx2, dy2, dist2, root2, m, lin, den, sq, gap;
    longint c, t;
    int cnt;
    point_t p;
    ax = it.f1x; ay = it.f1y; bx = it.f2x; by = it.f2y; dl = it.dl;
    calc_err = 1'b0;
    if (fx_abs(ax - bx) < 64'(eps_model)) begin
      // foci share x: symmetric about the focus
      sy = fx_clamp(ay + by);
      rad = fx_clamp(fx_clamp(fx_mult(dl, dl) - fx_mult(dl, sy)) + fx_mult(ay, by));
      rt = fx_root(rad);
      px[0] = fx_clamp(ax - rt);
      px[1] = fx_clamp(ax + rt);
      py[0] = sy / 2;
      py[1] = py[0];
      cnt = 2;
    end else if (fx_abs(ay - by) < 64'(eps_model)) begin
      // foci share y: one point at the midpoint
      mx = fx_clamp(ax + bx) / 2;
      ex = fx_clamp(mx - ax);
      num = fx_clamp(fx_clamp(fx_mult(ex, ex) + fx_mult(ay, ay)) - fx_mult(dl, dl));
      px[0] = mx;
      py[0] = fx_quot(num / 2, fx_clamp(ay - dl));
      cnt = 1;
    end else begin
      // general quadratic
      dx = fx_clamp(ax - bx);
      dy = fx_clamp(ay - by);
      dx2 = fx_mult(dx, dx);
      dy2 = fx_mult(dy, dy);
      dist2 = fx_clamp(dx2 + dy2);
      sy = fx_clamp(ay + by);
      rad = fx_mult(fx_mult(fx_mult(dx2, fx_clamp(dl - ay)), fx_clamp(dl - by)), dist2);
      rt = fx_root(rad);
      root2 = fx_clamp(rt + rt);
      m = fx_mult(dl, dx2);
      lin = fx_clamp(fx_clamp(0 - fx_clamp(m + m)) + fx_mult(sy, dist2));
      den = fx_clamp(dy2 + dy2);
      sq = fx_clamp(fx_mult(ax, ax) - fx_mult(bx, bx));
      gap = fx_clamp(by - ay);
      py[0] = fx_quot(fx_clamp(lin - root2), den);
      py[1] = fx_quot(fx_clamp(lin + root2), den);
      for (int k = 0; k < 2; k++) begin
        c = fx_clamp(fx_clamp(fx_clamp(py[k] + py[k]) - by) - ay);
        num = fx_clamp(sq + fx_mult(c, gap));
        px[k] = fx_quot(num / 2, dx);
      end
      if (px[0] > px[1]) begin
        t = px[0]; px[0] = px[1]; px[1] = t;
        t = py[0]; py[0] = py[1]; py[1] = t;
      end
      cnt = 2;
    end
    for (int k = 0; k < cnt; k++) begin
      p.px = fx_to_out(px[k]);
      p.py = fx_to_out(py[k]);
      p.last = (k == cnt - 1);
      pending_points.insert(pending_points.size(), p);
    end
    // the error flag covers every point of the item
    for (int k = 0; k < cnt; k++) begin
      pending_points[pending_points.size() - 1 - k].err = calc_err;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      points_seen++;
      if (m_tuser) error_points++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point x=%h y=%h", m_tdata[31:0], m_tdata[63:32]);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want.px || m_tdata[63:32] !== want.py ||
            m_tlast !== want.last || m_tuser !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h last=%b err=%b, got x=%h y=%h last=%b err=%b",
                     want.px, want.py, want.last, want.err,
                     m_tdata[31:0], m_tdata[63:32], m_tlast, m_tuser);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  // one input beat, with random gaps before it
  task automatic send_foci(foci_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {it.dl, it.f2y, it.f2x, it.f1y, it.f1x};
    do @(posedge clk); while (!s_tready);
    predict_breakpoints(it);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending_points.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    eps_model = val;
  endtask

  function automatic foci_t mk(int a, int b, int c, int d, int e);
    foci_t it;
    it.f1x = a; it.f1y = b; it.f2x = c; it.f2y = d; it.dl = e;
    return it;
  endfunction

  function automatic int near_val();
    return int'($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  function automatic int delta_below_eps();
    int d;
    d = (eps_model == 0) ? 0 : int'($urandom_range(0, eps_model - 1));
    return $urandom_range(1) ? d : -d;
  endfunction

  // mostly well-formed geometry, some raw noise
  function automatic foci_t random_foci();
    foci_t it;
    int sel;
    sel = $urandom_range(99);
    it = mk(near_val(), near_val(), near_val(), near_val(), near_val());
    if (sel < 20) begin
      it.f2x = it.f1x + delta_below_eps();
    end else if (sel < 40) begin
      it.f2y = it.f1y + delta_below_eps();
    end else if (sel < 55) begin
      // directrix at or below both foci, as on a real sweep line
      it.dl = (it.f1y < it.f2y ? it.f1y : it.f2y) - int'($urandom_range(0, 1 << 20));
    end else if (sel < 80) begin
      it = mk($urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  task automatic test_extremes();
    int mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_foci(mk(mx, mx, mx, mx, mx));
    send_foci(mk(mn, mn, mn, mn, mn));
    send_foci(mk(0, 0, 0, 0, 0));
    send_foci(mk(mx, mn, mn, mx, 0));
    send_foci(mk(mn, mx, mx, mn, mn));
    send_foci(mk(-1, -1, -1, -1, -1));
    drain_results();
  endtask

  task automatic test_cases();
    // shared x, directrix below both foci
    send_foci(mk(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 0));
    // shared x, directrix between foci gives a negative radicand
    send_foci(mk(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, -32'h0003_0000, 0));
    // shared y, one point at the midpoint
    send_foci(mk(-32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 32'h0004_0000, 32'h0001_0000));
    // shared y with the directrix on the foci: zero divisor
    send_foci(mk(-32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 32'h0004_0000, 32'h0004_0000));
    // general case in both orders so the points get swapped
    send_foci(mk(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0005_0000, 0));
    send_foci(mk(32'h0004_0000, 32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 0));
    // general case with far foci: output saturation
    send_foci(mk(32'h7000_0000, 32'h0001_0000, -32'h7000_0000, 32'h0100_0000, -32'h7000_0000));
    drain_results();
  endtask

  task automatic test_epsilon_edges();
    // epsilon zero: equal coordinates fall through to the general case
    write_epsilon(16'd0);
    send_foci(mk(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 0));
    send_foci(mk(-32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 32'h0004_0000, 0));
    drain_results();
    // widest epsilon: nearly one unit counts as equal
    write_epsilon(16'hFFFF);
    send_foci(mk(32'h0001_0000, 32'h0003_0000, 32'h0001_FFFE, 32'h0005_0000, 0));
    send_foci(mk(0, 32'h0004_0000, 32'h0006_0000, 32'h0004_FFFE, 0));
    send_foci(mk(0, 32'h0004_0000, 32'h0006_0000, 32'h0005_0000, 0));
    drain_results();
  endtask

  task automatic test_random_phase(int sidle, int ridle, int count, logic [15:0] eps);
    src_idle = sidle;
    snk_idle = ridle;
    write_epsilon(eps);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_results();
        write_epsilon(16'($urandom_range(0, 65535)));
      end
      send_foci(random_foci());
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    m_tready = 1'b0;
    eps_model = 16'd1;
    src_idle = 13;
    snk_idle = 53;
    mismatches = 0;
    items_sent = 0;
    points_seen = 0;
    error_points = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_cases();
    test_epsilon_edges();
    test_random_phase(13, 53, 340, 16'd1);
    test_random_phase(53, 13, 340, 16'h0400);
    test_random_phase(0, 0, 340, 16'hFFFF);

    $display("sent %0d foci pairs, checked %0d points (%0d flagged with math errors)",
             items_sent, points_seen, error_points);
    $display("epsilon swept over 0, 1, 0xFFFF and random values; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[parabola_breakpoint_intersect.f]
src/pbi_pkg.sv
src/pbi_ram.sv
src/pbi_front.sv
src/pbi_arith.sv
src/pbi_core.sv
src/parabola_breakpoint_intersect.sv
test/tb_top.sv
